>>> sv/ghbsp_pkg.sv
// shared types, constants and helpers for the ghb stride prefetcher
`timescale 1ns / 1ps
package ghbsp_pkg;
	localparam int HIST       = 8;
	localparam int STREAMS    = 4;
	localparam int QDEPTH     = 8;
	localparam int LINE_BYTES = 64;

	localparam int LINE_W   = 58;
	localparam int ADDR_W   = 64;
	localparam int THR_W    = 8;
	localparam int DEPTH_W  = 5;
	localparam int IDX_W    = 5;
	localparam int CONF_W   = 8;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int HW       = $clog2(HIST);
	localparam int SW       = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int QW       = $clog2(QDEPTH);
	localparam int CW       = $clog2(QDEPTH + 1);
	localparam int NW       = $clog2(STREAMS + 1);
	localparam int LB_SHIFT = $clog2(LINE_BYTES);

	localparam logic [CONF_W-1:0] CONF_MAX = '1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_CALC = 2'd1,
		PH_WAIT = 2'd2,
		PH_PREF = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_CTRL,
		SQ_DERIVE,
		SQ_PREF,
		SQ_OUT
	} seq_t;

	typedef enum logic [1:0] {
		DV_P0,
		DV_P1,
		DV_NEW
	} dv_pass_t;

	typedef enum logic {
		REG_THRESHOLD = 1'b0,
		REG_DEPTH     = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic              valid;
		logic [LINE_W-1:0] value;
		logic [CONF_W-1:0] conf;
	} stride_t;

	typedef struct packed {
		logic front;
		logic go;
		logic shift;
		logic derive_init;
		logic derive_step;
		logic derive_finish;
		logic wait_step;
		logic pref_end;
		logic pref_init;
		logic pref_step;
	} cmd_t;

	typedef struct packed {
		phase_t phase;
		logic   go;
		logic   mq_nonempty;
		logic   derive_fin;
		logic   pref_over;
		logic   k_last;
	} stat_t;

	function automatic logic [QW-1:0] q_slot(input logic [QW-1:0] h, input logic [CW-1:0] c);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(c);
		if (s >= (CW+1)'(QDEPTH)) s = s - (CW+1)'(QDEPTH);
		return s[QW-1:0];
	endfunction

	function automatic logic [CW-1:0] q_dist(input logic [QW-1:0] p, input logic [QW-1:0] h);
		logic [CW-1:0] r;
		if (p >= h) r = CW'(p) - CW'(h);
		else r = CW'(p) + CW'(QDEPTH) - CW'(h);
		return r;
	endfunction
endpackage

>>> sv/ghbsp_if.sv
// handshake interfaces for miss beats and prefetch beats
`timescale 1ns / 1ps
interface ghb_miss_if;
	import ghbsp_pkg::*;
	logic              valid;
	logic              ready;
	logic              miss_req;
	logic [LINE_W-1:0] miss_line_addr;
	logic              cache_ready;
	modport source (output valid, miss_req, miss_line_addr, cache_ready, input ready);
	modport sink (input valid, miss_req, miss_line_addr, cache_ready, output ready);
endinterface

interface ghb_pf_if;
	import ghbsp_pkg::*;
	logic              valid;
	logic              ready;
	logic              prefetch_valid;
	logic [ADDR_W-1:0] prefetch_addr;
	logic [1:0]        phase;
	logic              miss_dropped;
	modport source (output valid, prefetch_valid, prefetch_addr, phase, miss_dropped, input ready);
	modport sink (input valid, prefetch_valid, prefetch_addr, phase, miss_dropped, output ready);
endinterface

>>> sv/ghb_stride_prefetcher_unit.sv
// top level of the ghb stride prefetcher with apb register port
// sequence: a tick beat passes SQ_CTRL, then SQ_DERIVE in stride calc or SQ_PREF in a
// prefetch step, and SQ_OUT, where the result beat is offered; in idle or wait phase it goes
// from SQ_CTRL straight to SQ_OUT; the derivation tests one candidate per cycle
// throughput: one tick beat at a time; the next is taken after the result beat leaves
// reset: arst_n asynchronous active low clears history, strides, queues and phase
`timescale 1ns / 1ps
module ghb_stride_prefetcher_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	ghb_miss_if.sink                       miss_in,
	ghb_pf_if.source                       pf_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ghbsp_pkg::PADDR_W-1:0]  paddr,
	input  logic [ghbsp_pkg::PDATA_W-1:0]  pwdata,
	output logic [ghbsp_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready
);
	import ghbsp_pkg::*;

	logic [THR_W-1:0]   thr_q;
	logic [DEPTH_W-1:0] depth_q;
	reg_idx_t           reg_sel;
	cmd_t               cmd;
	stat_t              stat;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_W'(2);
			depth_q <= DEPTH_W'(4);
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_THRESHOLD: thr_q <= pwdata[THR_W-1:0];
				REG_DEPTH: depth_q <= pwdata[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_DEPTH: prdata = PDATA_W'(depth_q);
			default: prdata = PDATA_W'(thr_q);
		endcase
	end

	ghbsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (miss_in.valid),
		.in_ready  (miss_in.ready),
		.out_valid (pf_out.valid),
		.out_ready (pf_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ghbsp_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.thr            (thr_q),
		.depth          (depth_q),
		.miss_req       (miss_in.miss_req),
		.miss_line_addr (miss_in.miss_line_addr),
		.cache_ready    (miss_in.cache_ready),
		.pf_valid_q     (pf_out.prefetch_valid),
		.pf_addr_q      (pf_out.prefetch_addr),
		.dropped_q      (pf_out.miss_dropped)
	);

	assign pf_out.phase = stat.phase;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		pf_out.valid |-> !miss_in.ready)
		else $error("tick beat taken while a result beat is pending");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(miss_in.valid && miss_in.ready) |=> !pf_out.valid)
		else $error("result beat offered in the cycle after acceptance");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pf_out.valid && !pf_out.prefetch_valid) |-> (pf_out.prefetch_addr == '0))
		else $error("prefetch address nonzero without a prefetch");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.front, cmd.shift, cmd.derive_step, cmd.pref_step}))
		else $error("conflicting datapath commands");
endmodule

>>> sv/ghbsp_datapath.sv
// datapath: miss queue, history buffer, stride table, stream queues and arbiter
`timescale 1ns / 1ps
module ghbsp_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ghbsp_pkg::cmd_t                  cmd,
	output ghbsp_pkg::stat_t                 stat,
	input  logic [ghbsp_pkg::THR_W-1:0]      thr,
	input  logic [ghbsp_pkg::DEPTH_W-1:0]    depth,
	input  logic                             miss_req,
	input  logic [ghbsp_pkg::LINE_W-1:0]     miss_line_addr,
	input  logic                             cache_ready,
	output logic                             pf_valid_q,
	output logic [ghbsp_pkg::ADDR_W-1:0]     pf_addr_q,
	output logic                             dropped_q
);
	import ghbsp_pkg::*;

	logic              hist_valid_q [HIST];
	logic [LINE_W-1:0] hist_line_q [HIST];
	stride_t           stride_q [HIST][STREAMS];

	logic [LINE_W-1:0] miss_fifo_q [QDEPTH];
	logic [QW-1:0]     mq_head_q;
	logic [CW-1:0]     mq_count_q;

	logic [LINE_W-1:0] sq_data_q [STREAMS][QDEPTH];
	logic [QW-1:0]     sq_head_q [STREAMS];
	logic [CW-1:0]     sq_count_q [STREAMS];
	logic [LINE_W-1:0] cursor_q [STREAMS];
	logic [SW-1:0]     rr_q;

	phase_t            ph_q;
	logic [IDX_W-1:0]  idx_q;

	dv_pass_t          dv_pass_q;
	logic [HW-1:0]     dv_i_q;
	logic [HW-1:0]     dv_j_q;
	logic [SW-1:0]     dv_k_q;
	logic              dv_done_q;
	logic [NW-1:0]     n_q;
	logic [SW-1:0]     pk_q;

	// miss queue push
	logic              mq_full;
	logic [QW-1:0]     mq_h_eff;
	logic [CW-1:0]     mq_c_eff;

	// arbiter
	logic              arb_hit;
	logic [SW-1:0]     arb_q;

	// stride derivation
	logic [LINE_W-1:0] d_i;
	logic [LINE_W-1:0] s_pair;
	stride_t           cand;
	logic              seen;
	logic              slot_we;
	stride_t           slot_val;

	// prefetch walk
	stride_t           ps;
	logic [LINE_W-1:0] cur_new;
	logic              pf_active;
	logic              conf_clr;
	logic              dup;
	logic              enq;
	logic              go;

	always_comb begin
		mq_full  = (mq_count_q == CW'(QDEPTH));
		mq_h_eff = mq_full ? q_slot(mq_head_q, CW'(1)) : mq_head_q;
		mq_c_eff = mq_full ? (mq_count_q - CW'(1)) : mq_count_q;
	end

	always_comb begin
		logic [SW:0] qs;
		arb_hit = 1'b0;
		arb_q   = rr_q;
		for (int i = 1; i <= STREAMS; i++) begin
			qs = (SW+1)'(rr_q) + (SW+1)'(i);
			if (qs >= (SW+1)'(STREAMS)) qs = qs - (SW+1)'(STREAMS);
			if (!arb_hit && sq_count_q[qs[SW-1:0]] != '0) begin
				arb_hit = 1'b1;
				arb_q   = qs[SW-1:0];
			end
		end
	end

	always_comb begin
		go = 1'b0;
		for (int k = 0; k < STREAMS; k++)
			if (stride_q[0][k].valid && stride_q[0][k].conf > thr) go = 1'b1;
		go = go && hist_valid_q[0];
	end

	always_comb begin
		d_i    = hist_line_q[0] - hist_line_q[dv_i_q];
		s_pair = hist_line_q[dv_i_q] - hist_line_q[dv_j_q];
		cand   = stride_q[dv_i_q][dv_k_q];
		seen   = 1'b0;
		for (int k = 0; k < STREAMS; k++)
			if (stride_q[0][k].valid && stride_q[0][k].value == s_pair) seen = 1'b1;
		slot_we  = 1'b0;
		slot_val = '0;
		if (cmd.derive_step) begin
			case (dv_pass_q)
				DV_P0: begin
					if (hist_valid_q[dv_i_q] && cand.valid && cand.value == d_i &&
					    cand.conf != '0 && cand.value != '0) begin
						slot_we  = 1'b1;
						slot_val = '{valid: 1'b1, value: cand.value,
						             conf: (cand.conf == CONF_MAX) ? CONF_MAX :
						                   cand.conf + CONF_W'(1)};
					end
				end
				DV_P1: begin
					if (hist_valid_q[dv_i_q] && cand.valid && cand.value == d_i &&
					    cand.conf != '0 && cand.value == '0) begin
						slot_we  = 1'b1;
						slot_val = cand;
					end
				end
				DV_NEW: begin
					if (dv_j_q > dv_i_q && hist_valid_q[dv_i_q] && hist_valid_q[dv_j_q] &&
					    !seen && s_pair == d_i) begin
						slot_we  = 1'b1;
						slot_val = '{valid: 1'b1, value: s_pair, conf: CONF_W'(1)};
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		ps        = stride_q[0][pk_q];
		cur_new   = ((idx_q == '0) ? hist_line_q[0] : cursor_q[pk_q]) + ps.value;
		pf_active = cmd.pref_step && ps.valid && (ps.conf >= thr);
		conf_clr  = pf_active && (idx_q == (IDX_W'(depth) - IDX_W'(1)));
		dup       = 1'b0;
		for (int q = 0; q < STREAMS; q++)
			for (int p = 0; p < QDEPTH; p++)
				if (sq_data_q[q][p] == cur_new && q_dist(QW'(p), sq_head_q[q]) < sq_count_q[q])
					dup = 1'b1;
		enq = pf_active && (sq_count_q[pk_q] < CW'(QDEPTH)) && !dup;
	end

	always_comb begin
		stat.phase       = ph_q;
		stat.go          = go;
		stat.mq_nonempty = (mq_count_q != '0);
		stat.derive_fin  = dv_done_q || (n_q == NW'(STREAMS));
		stat.pref_over   = (idx_q >= IDX_W'(depth));
		stat.k_last      = (pk_q == SW'(STREAMS - 1));
	end

	// history and stride table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_valid_q <= '{default: 1'b0};
			hist_line_q  <= '{default: '0};
			stride_q     <= '{default: '0};
		end else begin
			if (cmd.shift) begin
				for (int i = HIST - 1; i > 0; i--) begin
					hist_valid_q[i] <= hist_valid_q[i-1];
					hist_line_q[i]  <= hist_line_q[i-1];
					stride_q[i]     <= stride_q[i-1];
				end
				hist_valid_q[0] <= 1'b1;
				hist_line_q[0]  <= miss_fifo_q[mq_head_q];
				stride_q[0]     <= '{default: '0};
			end
			if (slot_we) stride_q[0][n_q[SW-1:0]] <= slot_val;
			if (conf_clr) stride_q[0][pk_q].conf <= '0;
		end
	end

	// controller phase and sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= PH_IDLE;
			idx_q     <= '0;
			dv_pass_q <= DV_P0;
			dv_i_q    <= '0;
			dv_j_q    <= '0;
			dv_k_q    <= '0;
			dv_done_q <= 1'b0;
			n_q       <= '0;
			pk_q      <= '0;
		end else begin
			if (cmd.go) begin
				idx_q <= '0;
				ph_q  <= PH_PREF;
			end
			if (cmd.shift) ph_q <= PH_CALC;
			if (cmd.derive_init) begin
				dv_pass_q <= DV_P0;
				dv_i_q    <= HW'(1);
				dv_j_q    <= HW'(1);
				dv_k_q    <= '0;
				dv_done_q <= 1'b0;
				n_q       <= '0;
			end
			if (cmd.derive_step) begin
				if (slot_we) n_q <= n_q + NW'(1);
				if (dv_pass_q == DV_NEW) begin
					if (dv_j_q == HW'(HIST - 1)) begin
						dv_j_q <= HW'(1);
						if (dv_i_q == HW'(HIST - 1)) dv_done_q <= 1'b1;
						else dv_i_q <= dv_i_q + HW'(1);
					end else begin
						dv_j_q <= dv_j_q + HW'(1);
					end
				end else begin
					if (dv_k_q == SW'(STREAMS - 1)) begin
						dv_k_q <= '0;
						if (dv_i_q == HW'(HIST - 1)) begin
							dv_i_q    <= HW'(1);
							dv_pass_q <= (dv_pass_q == DV_P0) ? DV_P1 : DV_NEW;
						end else begin
							dv_i_q <= dv_i_q + HW'(1);
						end
					end else begin
						dv_k_q <= dv_k_q + SW'(1);
					end
				end
			end
			if (cmd.derive_finish) begin
				ph_q  <= PH_WAIT;
				idx_q <= '0;
			end
			if (cmd.wait_step) begin
				if (idx_q >= IDX_W'(STREAMS)) ph_q <= PH_IDLE;
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.pref_end) ph_q <= PH_IDLE;
			if (cmd.pref_init) pk_q <= '0;
			if (cmd.pref_step) begin
				pk_q <= pk_q + SW'(1);
				if (stat.k_last) idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// queue control and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mq_head_q  <= '0;
			mq_count_q <= '0;
			sq_head_q  <= '{default: '0};
			sq_count_q <= '{default: '0};
			rr_q       <= '0;
			pf_valid_q <= 1'b0;
			pf_addr_q  <= '0;
			dropped_q  <= 1'b0;
		end else begin
			if (cmd.front) begin
				if (miss_req) begin
					mq_head_q  <= mq_h_eff;
					mq_count_q <= mq_c_eff + CW'(1);
				end
				dropped_q  <= miss_req && mq_full;
				pf_valid_q <= cache_ready && arb_hit;
				pf_addr_q  <= '0;
				if (cache_ready && arb_hit) begin
					pf_addr_q         <= ADDR_W'(sq_data_q[arb_q][sq_head_q[arb_q]]) << LB_SHIFT;
					sq_head_q[arb_q]  <= q_slot(sq_head_q[arb_q], CW'(1));
					sq_count_q[arb_q] <= sq_count_q[arb_q] - CW'(1);
					rr_q              <= arb_q;
				end
			end
			if (cmd.shift) begin
				mq_head_q  <= q_slot(mq_head_q, CW'(1));
				mq_count_q <= mq_count_q - CW'(1);
			end
			if (enq) sq_count_q[pk_q] <= sq_count_q[pk_q] + CW'(1);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (cmd.front && miss_req) miss_fifo_q[q_slot(mq_h_eff, mq_c_eff)] <= miss_line_addr;
		if (cmd.pref_step) cursor_q[pk_q] <= cur_new;
		if (enq) sq_data_q[pk_q][q_slot(sq_head_q[pk_q], sq_count_q[pk_q])] <= cur_new;
	end
endmodule

>>> sv/ghbsp_ctrl.sv
// sequencer that steps the datapath through one tick
`timescale 1ns / 1ps
module ghbsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ghbsp_pkg::stat_t  stat,
	output ghbsp_pkg::cmd_t   cmd
);
	import ghbsp_pkg::*;

	seq_t state_q;
	seq_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= SQ_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: if (in_valid) state_d = SQ_CTRL;
			SQ_CTRL: begin
				case (stat.phase)
					PH_CALC: state_d = SQ_DERIVE;
					PH_PREF: state_d = stat.pref_over ? SQ_OUT : SQ_PREF;
					default: state_d = SQ_OUT;
				endcase
			end
			SQ_DERIVE: if (stat.derive_fin) state_d = SQ_OUT;
			SQ_PREF: if (stat.k_last) state_d = SQ_OUT;
			SQ_OUT: if (out_ready) state_d = SQ_IDLE;
			default: state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			SQ_IDLE: begin
				in_ready  = 1'b1;
				cmd.front = in_valid;
			end
			SQ_CTRL: begin
				case (stat.phase)
					PH_IDLE: begin
						cmd.go    = stat.go;
						cmd.shift = !stat.go && stat.mq_nonempty;
					end
					PH_CALC: cmd.derive_init = 1'b1;
					PH_WAIT: cmd.wait_step = 1'b1;
					PH_PREF: begin
						cmd.pref_end  = stat.pref_over;
						cmd.pref_init = !stat.pref_over;
					end
					default: ;
				endcase
			end
			SQ_DERIVE: begin
				cmd.derive_finish = stat.derive_fin;
				cmd.derive_step   = !stat.derive_fin;
			end
			SQ_PREF: cmd.pref_step = 1'b1;
			SQ_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

>>> verif/tb.sv
// self-checking testbench for the ghb stride prefetcher unit
`timescale 1ns / 1ps
module tb;
	import ghbsp_pkg::*;

	typedef struct {
		bit              pv;
		bit [ADDR_W-1:0] pa;
		phase_t          ph;
		bit              dropped;
	} tick_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	ghb_miss_if miss_if();
	ghb_pf_if   pf_if();

	ghb_stride_prefetcher_unit DUT (
		.clk(clk), .arst_n(arst_n), .miss_in(miss_if), .pf_out(pf_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	bit [THR_W-1:0]   thr;
	bit [DEPTH_W-1:0] dep;
	bit               hv[HIST];
	bit [LINE_W-1:0]  hl[HIST];
	bit               st_v[HIST][STREAMS];
	bit [LINE_W-1:0]  st_s[HIST][STREAMS];
	bit [CONF_W-1:0]  st_c[HIST][STREAMS];
	bit [LINE_W-1:0]  mq[QDEPTH];
	int               mq_h, mq_n;
	bit [LINE_W-1:0]  sq[STREAMS][QDEPTH];
	int               sq_h[STREAMS], sq_n[STREAMS];
	bit [LINE_W-1:0]  cursor[STREAMS];
	int               rr;
	phase_t           ctl;
	bit [IDX_W-1:0]   pidx;
	int               slots;

	tick_result_t expected_ticks[$];
	int  errors, items, prefetches, drops, bursts;
	bit  quiet, hold_req;

	function automatic void add_slot(bit [LINE_W-1:0] s, bit [CONF_W-1:0] c);
		if (slots >= STREAMS) return;
		st_v[0][slots] = 1;
		st_s[0][slots] = s;
		st_c[0][slots] = c;
		slots++;
	endfunction

	function automatic void derive_strides();
		bit [LINE_W-1:0] d[HIST];
		bit [LINE_W-1:0] s;
		bit seen;
		slots = 0;
		for (int i = 0; i < HIST; i++) d[i] = hl[0] - hl[i];
		for (int p = 0; p < 2; p++)
			for (int i = 1; i < HIST; i++) begin
				if (!hv[i]) continue;
				if (slots >= STREAMS) return;
				for (int k = 0; k < STREAMS; k++) begin
					if (!st_v[i][k] || st_s[i][k] != d[i] || st_c[i][k] == 0) continue;
					if (p == 0 && st_s[i][k] != 0)
						add_slot(st_s[i][k],
							st_c[i][k] == CONF_MAX ? CONF_MAX : st_c[i][k] + CONF_W'(1));
					else if (p == 1 && st_s[i][k] == 0)
						add_slot(st_s[i][k], st_c[i][k]);
				end
			end
		for (int i = 1; i < HIST; i++) begin
			if (!hv[i]) continue;
			if (slots >= STREAMS) return;
			for (int j = i + 1; j < HIST; j++) begin
				if (!hv[j]) continue;
				s = hl[i] - hl[j];
				seen = 0;
				for (int k = 0; k < STREAMS; k++)
					if (st_v[0][k] && st_s[0][k] == s) seen = 1;
				if (seen) continue;
				if (s == d[i]) add_slot(s, CONF_W'(1));
			end
		end
	endfunction

	function automatic bit in_stream_queues(bit [LINE_W-1:0] a);
		for (int q = 0; q < STREAMS; q++)
			for (int e = 0; e < sq_n[q]; e++)
				if (sq[q][(sq_h[q] + e) % QDEPTH] == a) return 1;
		return 0;
	endfunction

	function automatic void walk_streams();
		bit [LINE_W-1:0] base;
		if (pidx >= dep) begin
			ctl = PH_IDLE;
			return;
		end
		for (int k = 0; k < STREAMS; k++) begin
			base = (pidx == 0) ? hl[0] : cursor[k];
			cursor[k] = base + st_s[0][k];
			if (st_v[0][k] && st_c[0][k] >= thr) begin
				if (pidx == dep - 1) st_c[0][k] = 0;
				if (sq_n[k] >= QDEPTH) continue;
				if (!in_stream_queues(cursor[k])) begin
					sq[k][(sq_h[k] + sq_n[k]) % QDEPTH] = cursor[k];
					sq_n[k]++;
				end
			end
		end
		pidx++;
	endfunction

	function automatic tick_result_t predict_tick(bit mv, bit [LINE_W-1:0] a, bit cr);
		tick_result_t r;
		int q;
		bit go;
		r.pv = 0; r.pa = '0; r.dropped = 0;
		if (mv) begin
			if (mq_n >= QDEPTH) begin
				mq_h = (mq_h + 1) % QDEPTH;
				mq_n--;
				r.dropped = 1;
			end
			mq[(mq_h + mq_n) % QDEPTH] = a;
			mq_n++;
		end
		if (cr)
			for (int i = 1; i <= STREAMS; i++) begin
				q = (rr + i) % STREAMS;
				if (sq_n[q] == 0) continue;
				r.pa = {sq[q][sq_h[q]], 6'b0};
				r.pv = 1;
				sq_h[q] = (sq_h[q] + 1) % QDEPTH;
				sq_n[q]--;
				rr = q;
				break;
			end
		case (ctl)
			PH_IDLE: begin
				go = 0;
				if (hv[0])
					for (int k = 0; k < STREAMS; k++)
						if (st_v[0][k] && st_c[0][k] > thr) go = 1;
				if (go) begin
					pidx = 0;
					ctl = PH_PREF;
					bursts++;
				end else if (mq_n > 0) begin
					for (int i = HIST - 1; i > 0; i--) begin
						hv[i] = hv[i-1];
						hl[i] = hl[i-1];
						st_v[i] = st_v[i-1];
						st_s[i] = st_s[i-1];
						st_c[i] = st_c[i-1];
					end
					hv[0] = 1;
					hl[0] = mq[mq_h];
					for (int k = 0; k < STREAMS; k++) begin
						st_v[0][k] = 0; st_s[0][k] = '0; st_c[0][k] = '0;
					end
					mq_h = (mq_h + 1) % QDEPTH;
					mq_n--;
					ctl = PH_CALC;
				end
			end
			PH_CALC: begin
				derive_strides();
				pidx = 0;
				ctl = PH_WAIT;
			end
			PH_WAIT: begin
				if (pidx >= STREAMS) ctl = PH_IDLE;
				pidx++;
			end
			default: walk_streams();
		endcase
		r.ph = ctl;
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("FAILED: results differ");
		$finish;
	end

	// result beat checker
	always @(posedge clk) begin
		tick_result_t e;
		if (pf_if.valid && pf_if.ready) begin
			if (expected_ticks.size() == 0) begin
				$display("%0t: unexpected result beat pv=%0b addr=%h", $time,
					pf_if.prefetch_valid, pf_if.prefetch_addr);
				errors++;
			end else begin
				e = expected_ticks.pop_front();
				if (pf_if.prefetch_valid !== e.pv) begin
					$display("%0t: prefetch_valid exp %0b got %0b", $time, e.pv,
						pf_if.prefetch_valid);
					errors++;
				end
				if (pf_if.prefetch_addr !== e.pa) begin
					$display("%0t: prefetch_addr exp %h got %h", $time, e.pa,
						pf_if.prefetch_addr);
					errors++;
				end
				if (pf_if.phase !== e.ph) begin
					$display("%0t: phase exp %0d got %0d", $time, e.ph, pf_if.phase);
					errors++;
				end
				if (pf_if.miss_dropped !== e.dropped) begin
					$display("%0t: miss_dropped exp %0b got %0b", $time, e.dropped,
						pf_if.miss_dropped);
					errors++;
				end
				if (e.pv) prefetches++;
				if (e.dropped) drops++;
			end
		end
	end

	// receiver stalls and long hold-off
	always @(posedge clk) begin
		if (hold_req) begin
			pf_if.ready <= 0;
			repeat (300) @(posedge clk);
			hold_req <= 0;
		end else
			pf_if.ready <= (quiet || $urandom_range(99) >= 7);
	end

	task automatic send_tick(bit mv, bit [LINE_W-1:0] a, bit cr);
		if (!quiet && $urandom_range(99) < 7) begin
			miss_if.valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		miss_if.valid          <= 1;
		miss_if.miss_req       <= mv;
		miss_if.miss_line_addr <= a;
		miss_if.cache_ready    <= cr;
		do @(posedge clk); while (!miss_if.ready);
		expected_ticks.push_back(predict_tick(mv, a, cr));
		items++;
	endtask

	task automatic drain();
		miss_if.valid <= 0;
		wait (expected_ticks.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, bit [PDATA_W-1:0] v);
		@(posedge clk);
		psel    <= 1;
		pwrite  <= 1;
		penable <= 0;
		paddr   <= PADDR_W'(4 * idx);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
		if (idx == REG_THRESHOLD) thr = v[THR_W-1:0];
		else dep = v[DEPTH_W-1:0];
	endtask

	task automatic set_config(bit [THR_W-1:0] t, bit [DEPTH_W-1:0] d);
		drain();
		apb_write(REG_THRESHOLD, PDATA_W'(t));
		apb_write(REG_DEPTH, PDATA_W'(d));
	endtask

	task automatic send_stream(bit [LINE_W-1:0] base, bit [LINE_W-1:0] s, int n, int ready_pct);
		for (int i = 0; i < n; i++) begin
			send_tick(1, base + s * i, $urandom_range(99) < ready_pct);
			repeat ($urandom_range(0, 3))
				send_tick(0, LINE_W'({$urandom, $urandom}), 1'($urandom_range(1)));
		end
	endtask

	task automatic test_directed();
		set_config(0, 16);
		send_tick(1, '0, 1);
		send_tick(1, '1, 0);
		send_tick(0, '1, 1);
		send_tick(0, '0, 0);
		// wrapping stream near the top of the line space
		send_stream(58'h3ff_ffff_ffff_fff0, 5, 6, 0);
		// fill the miss queue so it drops
		for (int i = 0; i < 12; i++) send_tick(1, 58'h1000 + i * 3, 0);
		drain();
		// zero stride and saturation
		set_config(8'hff, 1);
		for (int i = 0; i < 10; i++) send_tick(1, 58'h777, 1);
		for (int i = 0; i < 10; i++) send_tick(1, 58'h5000 + i * 2, 1);
		// depth zero keeps re-entering prefetch
		set_config(0, 0);
		for (int i = 0; i < 5; i++) send_tick(1, 58'h9000 + i * 4, 1);
	endtask

	task automatic test_random_streams(int n_items);
		int stop;
		bit [LINE_W-1:0] s;
		stop = items + n_items;
		while (items < stop) begin
			if ($urandom_range(99) < 15) begin
				send_tick(1'($urandom_range(1)), LINE_W'({$urandom, $urandom}),
					1'($urandom_range(1)));
			end else begin
				case ($urandom_range(3))
					0: s = LINE_W'($urandom_range(1, 8));
					1: s = -LINE_W'($urandom_range(1, 8));
					2: s = LINE_W'({$urandom, $urandom});
					default: s = '0;
				endcase
				send_stream(LINE_W'({$urandom, $urandom}), s, $urandom_range(3, 12), 80);
			end
		end
	endtask

	task automatic test_config_sweep();
		set_config(8'hff, 16);
		test_random_streams(150);
		set_config(1, 1);
		test_random_streams(150);
		set_config(3, 9);
		test_random_streams(150);
		set_config(0, 2);
		test_random_streams(150);
	endtask

	task automatic test_backpressure();
		set_config(0, 16);
		hold_req <= 1;
		send_stream(58'h4_0000, 3, 30, 100);
		drain();
	endtask

	task automatic test_quiet_stretch();
		set_config(2, 4);
		quiet = 1;
		test_random_streams(300);
		quiet = 0;
		drain();
		test_random_streams(700);
	endtask

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		miss_if.valid = 0; miss_if.miss_req = 0;
		miss_if.miss_line_addr = '0; miss_if.cache_ready = 0;
		pf_if.ready = 0;
		quiet = 0; hold_req = 0;
		errors = 0; items = 0; prefetches = 0; drops = 0; bursts = 0;
		thr = 2; dep = 4;
		for (int i = 0; i < HIST; i++) begin
			hv[i] = 0; hl[i] = '0;
			for (int k = 0; k < STREAMS; k++) begin
				st_v[i][k] = 0; st_s[i][k] = '0; st_c[i][k] = '0;
			end
		end
		for (int k = 0; k < STREAMS; k++) begin
			sq_h[k] = 0; sq_n[k] = 0; cursor[k] = '0;
		end
		mq_h = 0; mq_n = 0; rr = 0; ctl = PH_IDLE; pidx = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_quiet_stretch();
		drain();
		$display("covered %0d ticks: %0d prefetches, %0d dropped misses, %0d bursts",
			items, prefetches, drops, bursts);
		$display("thresholds 0..255 and depths 0..16 swept with stalls on both sides");
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
